FILE: rtl/core/mfed_pkg.sv
// Shared types, constants and codes of the marker framed escape deframer.
`default_nettype none

package mfed_pkg;

  localparam int unsigned BufDepthDefault = 32;
  localparam int unsigned BufDepthMax     = 64;
  localparam int unsigned FillW           = $clog2(BufDepthMax + 1);
  localparam int unsigned IdxW            = $clog2(BufDepthMax);
  localparam int unsigned MaxResults      = 30;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [7:0] StartMarkerRst = 8'd254;
  localparam logic [7:0] EndMarkerRst   = 8'd255;
  localparam logic [7:0] EscapeRst      = 8'd253;
  localparam logic [4:0] ExpLenRst      = 5'd4;
  localparam logic [7:0] TimeoutRst     = 8'd50;

  typedef enum logic [1:0] {
    StOk,
    StLen,
    StOvf,
    StTimeout
  } status_e;

  typedef enum logic {
    ActByte,
    ActTick
  } action_e;

  typedef enum logic [2:0] {
    CfgStart,
    CfgEnd,
    CfgEscape,
    CfgExpLen,
    CfgTimeout
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkFetch,
    BkByte,
    BkEsc,
    BkOut,
    BkSingle
  } back_state_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    status_e    status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] escape_value;
    logic [4:0] expected_length;
    logic [7:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic             is_timeout;
    logic             overflow;
    logic             bank;
    logic [FillW-1:0] fill;
  } cmd_t;

  typedef struct packed {
    logic            we;
    logic            bank;
    logic [IdxW-1:0] idx;
    logic [7:0]      data;
  } store_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

`default_nettype wire

FILE: rtl/core/marker_framed_escape_deframer.sv
// Top level of the marker framed escape deframer.
`default_nettype none

// Received bytes and millisecond ticks enter through a queue-style port and
// are taken one per cycle, while full is low, by the front end, which tracks
// the open frame, counts idle ticks and writes payload bytes into one of two
// store banks. A closing marker or a timeout becomes a command in a two-entry
// queue; the back end then decodes the frame from the store in two passes
// over the single registered read port: a counting pass that fetches each
// stored byte, joins an escape pair into one result and counts the results,
// and an emitting pass that repeats these steps and pushes each result. A
// timeout or store overflow yields a single result. Input stalls (full high)
// only when the command queue is full or both store banks hold frames that
// are not yet drained. Results wait in a two-entry queue until popped.
// Configuration writes are accepted in every cycle (ready is tied high).
module marker_framed_escape_deframer #(
  parameter int unsigned BufDepth = mfed_pkg::BufDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_data_i,
  input  wire logic                push,
  input  wire mfed_pkg::in_item_t  in_item_i,
  output logic                     full,
  output logic                     empty,
  input  wire logic                pop,
  output mfed_pkg::out_item_t      out_item_o
);

  import mfed_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t      cmd_in, cmd_out;
  store_wr_t store_wr;
  release_t  rel;
  logic      res_push, res_full;
  out_item_t res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgStart:   cfg_d.start_marker    = cfg_data_i;
        CfgEnd:     cfg_d.end_marker      = cfg_data_i;
        CfgEscape:  cfg_d.escape_value    = cfg_data_i;
        CfgExpLen:  cfg_d.expected_length = cfg_data_i[4:0];
        CfgTimeout: cfg_d.timeout_ticks   = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker    <= StartMarkerRst;
      cfg_q.end_marker      <= EndMarkerRst;
      cfg_q.escape_value    <= EscapeRst;
      cfg_q.expected_length <= ExpLenRst;
      cfg_q.timeout_ticks   <= TimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mfed_front #(
    .BufDepth(BufDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .item_i     (in_item_i),
    .full_o     (full),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .wr_o       (store_wr),
    .rel_i      (rel)
  );

  mfed_fifo #(
    .DataT(cmd_t),
    .Depth(QueueDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  mfed_back #(
    .BufDepth(BufDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .wr_i        (store_wr),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res),
    .rel_o       (rel)
  );

  mfed_fifo #(
    .DataT(out_item_t),
    .Depth(QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

  a_cmd_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  a_res_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_data_not_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.byte_valid) |-> (out_item_o.status != StTimeout))
    else $error("decoded byte carries timeout status");

  a_mid_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.last) |-> out_item_o.byte_valid)
    else $error("non-final result without a byte");

endmodule

`default_nettype wire

FILE: rtl/core/mfed_fifo.sv
// Small first-in first-out queue with full and empty flags.
`default_nettype none

module mfed_fifo #(
  parameter type         DataT = logic,
  parameter int unsigned Depth = mfed_pkg::QueueDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire DataT  data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output DataT       data_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  DataT            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i & ~full_o;
  assign pop_ok  = pop_i & ~empty_o;
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mfed_front.sv
// Front end: frame tracking, idle tick counting, payload store writes and commands.
`default_nettype none

module mfed_front #(
  parameter int unsigned BufDepth = mfed_pkg::BufDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mfed_pkg::cfg_t      cfg_i,
  input  wire logic                push_i,
  input  wire mfed_pkg::in_item_t  item_i,
  output logic                     full_o,
  input  wire logic                cmd_full_i,
  output logic                     cmd_push_o,
  output mfed_pkg::cmd_t           cmd_o,
  output mfed_pkg::store_wr_t      wr_o,
  input  wire mfed_pkg::release_t  rel_i
);

  import mfed_pkg::*;

  localparam int unsigned CntW  = $clog2(BufDepth + 1);
  localparam int unsigned AddrW = $clog2(BufDepth);

  logic            in_frame_q, in_frame_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [7:0]      idle_q, idle_d;
  logic            bank_q, bank_d;
  logic [1:0]      busy_q, busy_d;
  logic            accept;

  assign full_o = cmd_full_i | busy_q[bank_q];
  assign accept = push_i & ~full_o;

  always_comb begin
    in_frame_d = in_frame_q;
    ovf_d      = ovf_q;
    fill_d     = fill_q;
    idle_d     = idle_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    wr_o       = '0;
    wr_o.bank  = bank_q;
    wr_o.idx   = IdxW'(fill_q[AddrW-1:0]);
    wr_o.data  = item_i.rx_byte;

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (accept) begin
      if (item_i.action == ActTick) begin
        if (idle_q >= cfg_i.timeout_ticks) begin
          idle_d           = '0;
          cmd_push_o       = 1'b1;
          cmd_o.is_timeout = 1'b1;
        end else begin
          idle_d = idle_q + 8'd1;
        end
      end else begin
        idle_d = '0;
        if (item_i.rx_byte == cfg_i.start_marker) begin
          in_frame_d = 1'b1;
          fill_d     = '0;
          ovf_d      = 1'b0;
        end else if (in_frame_q && (item_i.rx_byte != cfg_i.end_marker)) begin
          if (fill_q < CntW'(BufDepth)) begin
            wr_o.we = 1'b1;
            fill_d  = fill_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        if ((item_i.rx_byte == cfg_i.end_marker) && in_frame_d) begin
          cmd_push_o     = 1'b1;
          cmd_o.overflow = ovf_d;
          cmd_o.bank     = bank_q;
          cmd_o.fill     = FillW'(fill_d);
          in_frame_d     = 1'b0;
          fill_d         = '0;
          ovf_d          = 1'b0;
          bank_d         = ~bank_q;
          busy_d[bank_q] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      ovf_q      <= 1'b0;
      fill_q     <= '0;
      idle_q     <= '0;
      bank_q     <= 1'b0;
      busy_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      ovf_q      <= ovf_d;
      fill_q     <= fill_d;
      idle_q     <= idle_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mfed_back.sv
// Back end: payload store, two pass escape decoder and result generation.
`default_nettype none

module mfed_back #(
  parameter int unsigned BufDepth = mfed_pkg::BufDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mfed_pkg::cfg_t      cfg_i,
  input  wire mfed_pkg::store_wr_t wr_i,
  input  wire logic                cmd_empty_i,
  input  wire mfed_pkg::cmd_t      cmd_i,
  output logic                     cmd_pop_o,
  input  wire logic                res_full_i,
  output logic                     res_push_o,
  output mfed_pkg::out_item_t      res_o,
  output mfed_pkg::release_t       rel_o
);

  import mfed_pkg::*;

  localparam int unsigned CntW  = $clog2(BufDepth + 1);
  localparam int unsigned AddrW = $clog2(BufDepth);

  logic [7:0]      store_q [2**(AddrW+1)];
  logic [7:0]      rd_data_q;

  back_state_e     state_q, state_d;
  logic            bank_q, bank_d;
  logic            frame_q, frame_d;
  logic            pass_q, pass_d;
  logic [CntW-1:0] lim_q, lim_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] n_q, n_d;
  logic [7:0]      x_q, x_d;
  logic [7:0]      val_q, val_d;
  status_e         st_q, st_d;
  logic [CntW-1:0] rd_pos;
  logic [CntW-1:0] i_next;
  logic            fin;

  assign i_next = i_q + CntW'(1);
  assign rd_pos = (state_q == BkByte) ? i_next : i_q;
  assign fin    = (n_q == CntW'(1));

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      store_q[{wr_i.bank, wr_i.idx[AddrW-1:0]}] <= wr_i.data;
    end
    rd_data_q <= store_q[{bank_q, rd_pos[AddrW-1:0]}];
  end

  always_comb begin
    state_d    = state_q;
    bank_d     = bank_q;
    frame_d    = frame_q;
    pass_d     = pass_q;
    lim_d      = lim_q;
    i_d        = i_q;
    n_d        = n_q;
    x_d        = x_q;
    val_d      = val_q;
    st_d       = st_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    rel_o      = '0;
    rel_o.bank = bank_q;

    case (state_q)
      BkIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          bank_d    = cmd_i.bank;
          lim_d     = CntW'(cmd_i.fill);
          frame_d   = ~cmd_i.is_timeout;
          pass_d    = 1'b0;
          i_d       = '0;
          n_d       = '0;
          if (cmd_i.is_timeout) begin
            st_d    = StTimeout;
            state_d = BkSingle;
          end else if (cmd_i.overflow) begin
            st_d    = StOvf;
            state_d = BkSingle;
          end else begin
            state_d = BkFetch;
          end
        end
      end
      BkFetch: begin
        if (i_q < lim_q) begin
          state_d = BkByte;
        end else if (pass_q) begin
          rel_o.valid = frame_q;
          state_d     = BkIdle;
        end else if (8'(n_q) > 8'(MaxResults)) begin
          st_d    = StOvf;
          state_d = BkSingle;
        end else begin
          st_d = (8'(n_q) == 8'(cfg_i.expected_length)) ? StOk : StLen;
          if (n_q == '0) begin
            state_d = BkSingle;
          end else begin
            pass_d  = 1'b1;
            i_d     = '0;
            state_d = BkFetch;
          end
        end
      end
      BkByte: begin
        if (rd_data_q == cfg_i.escape_value) begin
          if (i_next < lim_q) begin
            x_d     = rd_data_q;
            state_d = BkEsc;
          end else begin
            val_d   = rd_data_q + cfg_i.end_marker;
            i_d     = i_next;
            state_d = BkOut;
          end
        end else begin
          val_d   = rd_data_q;
          i_d     = i_next;
          state_d = BkOut;
        end
      end
      BkEsc: begin
        val_d   = x_q + rd_data_q;
        i_d     = i_q + CntW'(2);
        state_d = BkOut;
      end
      BkOut: begin
        if (!pass_q) begin
          n_d     = n_q + CntW'(1);
          state_d = BkFetch;
        end else if (!res_full_i) begin
          res_push_o       = 1'b1;
          res_o.out_byte   = val_q;
          res_o.byte_valid = 1'b1;
          res_o.last       = fin;
          res_o.status     = fin ? st_q : StOk;
          n_d              = n_q - CntW'(1);
          if (fin) begin
            rel_o.valid = 1'b1;
            state_d     = BkIdle;
          end else begin
            state_d = BkFetch;
          end
        end
      end
      BkSingle: begin
        if (!res_full_i) begin
          res_push_o   = 1'b1;
          res_o.last   = 1'b1;
          res_o.status = st_q;
          rel_o.valid  = frame_q;
          state_d      = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      bank_q  <= 1'b0;
      frame_q <= 1'b0;
      pass_q  <= 1'b0;
      lim_q   <= '0;
      i_q     <= '0;
      n_q     <= '0;
      st_q    <= StOk;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      frame_q <= frame_d;
      pass_q  <= pass_d;
      lim_q   <= lim_d;
      i_q     <= i_d;
      n_q     <= n_d;
      st_q    <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    val_q <= val_d;
  end

endmodule

`default_nettype wire

FILE: verif/mfed_frame_monitor.sv
// Watches the deframer's channels, predicts its decoded results and checks them.
module mfed_frame_monitor
  import mfed_pkg::*;
#(
  parameter int unsigned BufDepth = BufDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push_i,
  input  logic       full_i,
  input  in_item_t   in_item_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  out_item_t  out_item_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] start_mk;
  logic [7:0] end_mk;
  logic [7:0] esc_val;
  logic [4:0] exp_len;
  logic [7:0] tmo_ticks;

  logic [7:0] frame_bytes [BufDepth];
  int         fill;
  bit         frame_open;
  bit         overran;
  int         idle_ticks;
  out_item_t  decoded_q [$];
  int         fails;

  function automatic out_item_t make_result(logic [7:0] b, logic v, logic l, status_e s);
    out_item_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.last       = l;
    r.status     = s;
    return r;
  endfunction

  // Decode the stored payload and queue what the block should emit for it.
  function automatic void decode_frame();
    logic [7:0] dec [$];
    logic [7:0] x;
    status_e    st;
    int         i;
    if (overran) begin
      decoded_q.push_back(make_result(8'h00, 1'b0, 1'b1, StOvf));
      return;
    end
    i = 0;
    while (i < fill) begin
      x = frame_bytes[i];
      if (x == esc_val) begin
        x = x + ((i + 1 < fill) ? frame_bytes[i + 1] : end_mk);
        i++;
      end
      dec.push_back(x);
      i++;
    end
    if (dec.size() > MaxResults) begin
      decoded_q.push_back(make_result(8'h00, 1'b0, 1'b1, StOvf));
      return;
    end
    st = (dec.size() == exp_len) ? StOk : StLen;
    if (dec.size() == 0) begin
      decoded_q.push_back(make_result(8'h00, 1'b0, 1'b1, st));
      return;
    end
    foreach (dec[k]) begin
      if (k == dec.size() - 1) begin
        decoded_q.push_back(make_result(dec[k], 1'b1, 1'b1, st));
      end else begin
        decoded_q.push_back(make_result(dec[k], 1'b1, 1'b0, StOk));
      end
    end
  endfunction

  function automatic void deframe_step(in_item_t it);
    logic [7:0] b;
    b = it.rx_byte;
    if (it.action == ActTick) begin
      if (idle_ticks >= tmo_ticks) begin
        idle_ticks = 0;
        decoded_q.push_back(make_result(8'h00, 1'b0, 1'b1, StTimeout));
      end else begin
        idle_ticks++;
      end
      return;
    end
    idle_ticks = 0;
    if (b == start_mk) begin
      frame_open = 1'b1;
      fill       = 0;
      overran    = 1'b0;
    end else if (frame_open && b != end_mk) begin
      if (fill < BufDepth) begin
        frame_bytes[fill] = b;
        fill++;
      end else begin
        overran = 1'b1;
      end
    end
    if (b == end_mk && frame_open) begin
      decode_frame();
      frame_open = 1'b0;
      fill       = 0;
      overran    = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mk   = StartMarkerRst;
      end_mk     = EndMarkerRst;
      esc_val    = EscapeRst;
      exp_len    = ExpLenRst;
      tmo_ticks  = TimeoutRst;
      fill       = 0;
      frame_open = 1'b0;
      overran    = 1'b0;
      idle_ticks = 0;
      fails      = 0;
      decoded_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // check before predicting: a result can never belong to this edge's input
      if (pop_i && !empty_i) begin
        if (decoded_q.size() == 0) begin
          fails++;
          $display("%0t unexpected result: expected none, got byte %02h valid %b last %b status %0d",
                   $time, out_item_i.out_byte, out_item_i.byte_valid, out_item_i.last,
                   out_item_i.status);
        end else begin
          if (out_item_i.out_byte !== decoded_q[0].out_byte ||
              out_item_i.byte_valid !== decoded_q[0].byte_valid ||
              out_item_i.last !== decoded_q[0].last ||
              out_item_i.status !== decoded_q[0].status) begin
            fails++;
            $display("%0t mismatch: expected byte %02h valid %b last %b status %0d, got byte %02h valid %b last %b status %0d",
                     $time, decoded_q[0].out_byte, decoded_q[0].byte_valid, decoded_q[0].last,
                     decoded_q[0].status, out_item_i.out_byte, out_item_i.byte_valid,
                     out_item_i.last, out_item_i.status);
          end
          void'(decoded_q.pop_front());
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgStart:   start_mk  = cfg_data_i;
          CfgEnd:     end_mk    = cfg_data_i;
          CfgEscape:  esc_val   = cfg_data_i;
          CfgExpLen:  exp_len   = cfg_data_i[4:0];
          CfgTimeout: tmo_ticks = cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        deframe_step(in_item_i);
      end
      fail_count_o <= fails;
      pending_o    <= decoded_q.size();
    end
  end

endmodule

FILE: verif/marker_framed_escape_deframer_test.sv
// Testbench top: drives directed and random frames, ticks and register settings.
module marker_framed_escape_deframer_test
  import mfed_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = BufDepthDefault;
  localparam int CycleLimit     = 400000;
  localparam int HoldCycles     = 400;
  localparam int SettleCycles   = 300;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;
  logic       push;
  logic       full;
  logic       empty;
  logic       pop;
  in_item_t   in_item;
  out_item_t  out_item;

  int fail_count;
  int pending;
  bit idle_on;
  int hold_reqs;
  int items_sent;

  logic [7:0] sh_start;
  logic [7:0] sh_end;
  logic [7:0] sh_esc;
  logic [4:0] sh_len;
  logic [7:0] sh_tmo;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  marker_framed_escape_deframer #(
    .BufDepth(Depth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .push       (push),
    .in_item_i  (in_item),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  mfed_frame_monitor #(
    .BufDepth(Depth)
  ) i_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .push_i      (push),
    .full_i      (full),
    .in_item_i   (in_item),
    .empty_i     (empty),
    .pop_i       (pop),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int stall_left;
    int holds_seen;
    stall_left = 0;
    holds_seen = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (holds_seen != hold_reqs) begin
        holds_seen = hold_reqs;
        pop <= 1'b0;
        stall_left = HoldCycles - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_item(input action_e act, input logic [7:0] b);
    in_item_t it;
    int       gap;
    it.action  = act;
    it.rx_byte = b;
    if (idle_on && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 11);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
    end
    @(negedge clk_i);
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  // stop offering, wait for every outstanding result, then let the block go quiet
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      CfgStart:   sh_start = v;
      CfgEnd:     sh_end   = v;
      CfgEscape:  sh_esc   = v;
      CfgExpLen:  sh_len   = v[4:0];
      CfgTimeout: sh_tmo   = v;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x,
                            input logic [7:0] l, input logic [7:0] t);
    settle();
    write_reg(CfgStart, s);
    write_reg(CfgEnd, e);
    write_reg(CfgEscape, x);
    write_reg(CfgExpLen, l);
    write_reg(CfgTimeout, t);
  endtask

  // payload byte that neither frames nor escapes
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == sh_start || b == sh_end || b == sh_esc);
    return b;
  endfunction

  function automatic logic [7:0] any_payload_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == sh_start || b == sh_end);
    return b;
  endfunction

  task automatic send_frame(input int n_dec, input bit trailing);
    bit esc_ok;
    esc_ok = (sh_esc != sh_start) && (sh_esc != sh_end);
    send_item(ActByte, sh_start);
    for (int k = 0; k < n_dec; k++) begin
      if ($urandom_range(0, 15) == 0) send_item(ActTick, 8'($urandom));
      if (esc_ok && $urandom_range(0, 4) == 0) begin
        send_item(ActByte, sh_esc);
        send_item(ActByte, any_payload_byte());
      end else begin
        send_item(ActByte, plain_byte());
      end
    end
    if (trailing && esc_ok) send_item(ActByte, sh_esc);
    send_item(ActByte, sh_end);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(ActTick, 8'($urandom));
  endtask

  task automatic run_random(input int budget);
    int stop_at;
    int r;
    int q;
    int n;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        q = $urandom_range(0, 9);
        if (q < 4) n = sh_len;
        else if (q < 8) n = $urandom_range(0, 6);
        else if (q == 8) n = $urandom_range(28, 31);
        else n = 1;
        send_frame(n, $urandom_range(0, 7) == 0);
      end else if (r < 65) begin
        // at or over the decoded byte limit, or too long for the store
        send_item(ActByte, sh_start);
        repeat ($urandom_range(30, 35)) send_item(ActByte, plain_byte());
        send_item(ActByte, sh_end);
      end else if (r < 80) begin
        send_ticks($urandom_range(1, (sh_tmo < 12) ? sh_tmo + 2 : 6));
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) send_item(ActByte, 8'($urandom));
      end else begin
        // frame cut short, to be restarted by a later start marker
        send_item(ActByte, sh_start);
        repeat ($urandom_range(0, 5)) send_item(ActByte, any_payload_byte());
      end
    end
  endtask

  initial begin : stimulus
    rst_ni     = 1'b0;
    push       = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idle_on    = 1'b1;
    hold_reqs  = 0;
    items_sent = 0;
    sh_start   = StartMarkerRst;
    sh_end     = EndMarkerRst;
    sh_esc     = EscapeRst;
    sh_len     = ExpLenRst;
    sh_tmo     = TimeoutRst;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: start FE, end FF, escape FD, length 4
    send_item(ActByte, 8'hFF);  // end marker with no frame open
    send_item(ActByte, 8'h00);  // stray byte
    send_item(ActByte, 8'hFE);  // frame decoding to 00 FF FC 01, status ok
    send_item(ActByte, 8'h00);
    send_item(ActByte, 8'hFD);
    send_item(ActByte, 8'h02);
    send_item(ActByte, 8'hFC);
    send_item(ActByte, 8'h01);
    send_item(ActByte, 8'hFF);
    send_item(ActByte, 8'hFE);  // empty frame
    send_item(ActByte, 8'hFF);
    send_item(ActByte, 8'hFE);  // restart inside a frame
    send_item(ActByte, 8'h11);
    send_item(ActByte, 8'hFE);
    send_item(ActByte, 8'h22);
    send_item(ActByte, 8'hFF);
    send_item(ActByte, 8'hFE);  // escape as final payload byte takes the end marker
    send_item(ActByte, 8'hFD);
    send_item(ActByte, 8'hFF);
    send_item(ActTick, 8'hFF);
    run_random(12);

    set_config(8'h00, 8'hFF, 8'h80, 8'd1, 8'd1);
    hold_reqs++;
    run_random(25);

    settle();
    run_random(8);

    set_config(8'hFF, 8'h00, 8'h01, 8'd30, 8'd255);
    run_random(10);

    // start equal to end
    set_config(8'h5A, 8'h5A, 8'h5B, 8'd3, 8'd7);
    run_random(8);

    set_config(8'h10, 8'h20, 8'hFF, 8'd16, 8'd2);
    idle_on = 1'b0;
    run_random(12);

    settle();
    if (pending != 0) $display("%0t %0d decoded results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
